// ===== design/i2cms_pkg.sv =====
// Package for the tick-driven I2C master sequencer.
// Holds word types, command and status codes, bus phase encoding and widths.
// No dependencies.
package i2cms_pkg;

	localparam int TIMER_BITS = 24;
	localparam int HALF_W = 16;
	localparam int TOUT_W = 24;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 1;
	localparam int ACK_CMP_W = (TIMER_BITS > TOUT_W) ? TIMER_BITS : TOUT_W;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(1);
	localparam logic [TOUT_W-1:0] ACK_TIMEOUT_RST = TOUT_W'(100);
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

	localparam logic [2:0] FUNC_NONE = 3'd0;
	localparam logic [2:0] FUNC_START_WR = 3'd1;
	localparam logic [2:0] FUNC_START_RD = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_READ = 3'd4;
	localparam logic [2:0] FUNC_STOP = 3'd5;

	localparam logic [1:0] ST_ACK = 2'd0;
	localparam logic [1:0] ST_NAK = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_TX_LOW, PH_TX_DATA, PH_TX_HIGH,
		PH_AK_LOW, PH_AK_HIGH, PH_RX_LOW, PH_RX_HIGH,
		PH_RA_LOW, PH_RA_DATA, PH_RA_HIGH, PH_RA_END,
		PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D
	} phase_t;

	typedef struct packed {
		logic [2:0] func;
		logic [6:0] addr;
		logic [7:0] wdata;
		logic [7:0] byte_count;
		logic       sda_level;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] rdata;
		logic [7:0] remaining;
	} res_t;

	typedef struct packed {
		logic [HALF_W-1:0] half_period;
		logic [TOUT_W-1:0] ack_timeout;
	} cfg_t;

endpackage

// ===== design/i2cms_if.sv =====
// Valid/ready channel interfaces for the I2C master sequencer.
// Depends on i2cms_pkg for the word types.
interface i2cms_cmd_if;
	import i2cms_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cms_res_if;
	import i2cms_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/i2cms_engine.sv =====
// Bus sequencer state and per-tick next-state logic of the I2C master.
// Depends on i2cms_pkg.
module i2cms_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2cms_pkg::cmd_t   cmd,
	input  i2cms_pkg::cfg_t   cfg,
	output i2cms_pkg::res_t   res
);
	import i2cms_pkg::*;

	phase_t                ph_q, ph_n, ent_p;
	logic [3:0]            bit_q, bit_n;
	logic [7:0]            shift_q, shift_n;
	logic [HALF_W-1:0]     pt_q, pt_n;
	logic [HALF_W:0]       pt_inc;
	logic [TIMER_BITS-1:0] at_q, at_n, at_inc;
	logic [7:0]            bl_q, bl_n;
	logic                  scl_q, scl_n, sda_q, sda_n, dir_q, dir_n;
	logic [1:0]            lst_q, lst_n;
	logic [7:0]            lrd_q, lrd_n;
	logic                  sst_q, sst_n;
	logic                  done, ignored, ent;

	always_comb begin
		ph_n = ph_q; bit_n = bit_q; shift_n = shift_q; pt_n = pt_q; at_n = at_q;
		bl_n = bl_q; scl_n = scl_q; sda_n = sda_q; dir_n = dir_q;
		lst_n = lst_q; lrd_n = lrd_q; sst_n = sst_q;
		done = 1'b0; ignored = 1'b0; ent = 1'b0; ent_p = PH_IDLE;
		pt_inc = {1'b0, pt_q} + (HALF_W+1)'(1);
		at_inc = (at_q < TIMER_MAX) ? at_q + TIMER_BITS'(1) : at_q;

		if (ph_q == PH_IDLE) begin
			unique case (cmd.func)
				FUNC_START_WR, FUNC_START_RD: begin
					if (cmd.func == FUNC_START_RD) bl_n = cmd.byte_count;
					shift_n = {cmd.addr, cmd.func == FUNC_START_RD};
					bit_n = '0;
					ent = 1'b1; ent_p = PH_ST_A;
				end
				FUNC_WRITE: begin
					shift_n = cmd.wdata; bit_n = '0;
					ent = 1'b1; ent_p = PH_TX_LOW;
				end
				FUNC_READ: begin
					if (bl_q == 8'd0) begin
						lrd_n = 8'd0; lst_n = ST_ACK; done = 1'b1; pt_n = '0;
					end else begin
						shift_n = 8'd0; bit_n = '0;
						ent = 1'b1; ent_p = PH_RX_LOW;
					end
				end
				FUNC_STOP: begin
					sst_n = 1'b0;
					ent = 1'b1; ent_p = PH_SP_A;
				end
				default: begin
				end
			endcase
		end else begin
			ignored = (cmd.func >= FUNC_START_WR) && (cmd.func <= FUNC_STOP);
			if (ph_q == PH_AK_HIGH) begin
				if (!cmd.sda_level) begin
					ph_n = PH_IDLE; pt_n = '0; lst_n = ST_ACK; done = 1'b1;
				end else begin
					at_n = at_inc;
					if (ACK_CMP_W'(at_inc) >= ACK_CMP_W'(cfg.ack_timeout) ||
					    at_inc == TIMER_MAX) begin
						ph_n = PH_IDLE; pt_n = '0; lst_n = ST_NAK; done = 1'b1;
					end
				end
			end else if (pt_inc >= {1'b0, cfg.half_period}) begin
				unique case (ph_q)
					PH_ST_A:    begin ent = 1'b1; ent_p = PH_ST_B; end
					PH_ST_B:    begin bit_n = '0; ent = 1'b1; ent_p = PH_TX_LOW; end
					PH_TX_LOW:  begin ent = 1'b1; ent_p = PH_TX_DATA; end
					PH_TX_DATA: begin ent = 1'b1; ent_p = PH_TX_HIGH; end
					PH_TX_HIGH: begin
						shift_n = {shift_q[6:0], 1'b0};
						bit_n = bit_q + 4'd1;
						ent = 1'b1;
						ent_p = (bit_n >= BITS_PER_BYTE) ? PH_AK_LOW : PH_TX_LOW;
					end
					PH_AK_LOW:  begin ent = 1'b1; ent_p = PH_AK_HIGH; end
					PH_RX_LOW:  begin ent = 1'b1; ent_p = PH_RX_HIGH; end
					PH_RX_HIGH: begin
						shift_n = {shift_q[6:0], cmd.sda_level};
						bit_n = bit_q + 4'd1;
						ent = 1'b1;
						if (bit_n >= BITS_PER_BYTE) begin
							lrd_n = shift_n;
							bl_n = bl_q - 8'd1;
							ent_p = PH_RA_LOW;
						end else begin
							ent_p = PH_RX_LOW;
						end
					end
					PH_RA_LOW:  begin ent = 1'b1; ent_p = PH_RA_DATA; end
					PH_RA_DATA: begin ent = 1'b1; ent_p = PH_RA_HIGH; end
					PH_RA_HIGH: begin ent = 1'b1; ent_p = PH_RA_END; end
					PH_RA_END: begin
						if (bl_q == 8'd0) begin
							sst_n = 1'b1; ent = 1'b1; ent_p = PH_SP_A;
						end else begin
							ph_n = PH_IDLE; pt_n = '0; lst_n = ST_ACK; done = 1'b1;
						end
					end
					PH_SP_A:    begin ent = 1'b1; ent_p = PH_SP_B; end
					PH_SP_B:    begin ent = 1'b1; ent_p = PH_SP_C; end
					PH_SP_C:    begin ent = 1'b1; ent_p = PH_SP_D; end
					PH_SP_D: begin
						ph_n = PH_IDLE; pt_n = '0; lst_n = {1'b0, sst_q}; done = 1'b1;
					end
					default: begin
						ph_n = PH_IDLE; pt_n = '0; lst_n = ST_ACK; done = 1'b1;
					end
				endcase
			end else begin
				pt_n = pt_inc[HALF_W-1:0];
			end
		end

		if (ent) begin
			ph_n = ent_p;
			pt_n = '0;
			unique case (ent_p)
				PH_ST_A, PH_TX_HIGH, PH_RX_HIGH, PH_RA_HIGH, PH_SP_C: scl_n = 1'b1;
				PH_TX_LOW, PH_RA_LOW, PH_RA_END, PH_SP_A: scl_n = 1'b0;
				PH_ST_B, PH_SP_B: begin sda_n = 1'b0; dir_n = 1'b1; end
				PH_SP_D: begin sda_n = 1'b1; dir_n = 1'b1; end
				PH_TX_DATA: begin sda_n = shift_n[7]; dir_n = 1'b1; end
				PH_RA_DATA: begin sda_n = (bl_n == 8'd0); dir_n = 1'b1; end
				PH_AK_LOW, PH_RX_LOW: begin scl_n = 1'b0; dir_n = 1'b0; end
				PH_AK_HIGH: begin scl_n = 1'b1; at_n = '0; end
				default: begin
				end
			endcase
		end

		res.scl_out = scl_n;
		res.sda_out = sda_n;
		res.sda_drive = dir_n;
		res.busy_res = (ph_n != PH_IDLE);
		res.done_res = done;
		res.status = (!done && ignored) ? ST_IGNORED : lst_n;
		res.rdata = lrd_n;
		res.remaining = bl_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; bit_q <= '0; shift_q <= '0; pt_q <= '0; at_q <= '0;
			bl_q <= '0; scl_q <= 1'b1; sda_q <= 1'b1; dir_q <= 1'b1;
			lst_q <= ST_ACK; lrd_q <= '0; sst_q <= 1'b0;
		end else if (step) begin
			ph_q <= ph_n; bit_q <= bit_n; shift_q <= shift_n; pt_q <= pt_n; at_q <= at_n;
			bl_q <= bl_n; scl_q <= scl_n; sda_q <= sda_n; dir_q <= dir_n;
			lst_q <= lst_n; lrd_q <= lrd_n; sst_q <= sst_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step && ph_q == PH_AK_HIGH |-> !dir_q && scl_q)
		else $error("ack wait without released SDA and high SCL");
	assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_IDLE |-> pt_q == '0)
		else $error("phase timer not cleared while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		step && ph_q == PH_IDLE && cmd.func == FUNC_STOP |=> !scl_q && ph_q == PH_SP_A)
		else $error("stop did not pull SCL low first");
endmodule

// ===== design/i2c_master_sequencer_core.sv =====
// Top level of the tick-driven I2C master sequencer: config registers,
// input register, sequencer engine and result register.
// Depends on i2cms_pkg, i2cms_if and i2cms_engine.
//
//  channel | dir | word  | contents
//  cmd     | in  | cmd_t | func, addr, wdata, byte_count, sda_level (one tick)
//  res     | out | res_t | pin levels, busy, done, status, rdata, remaining
//  cfg_*   | in  | -     | write enable, index, 24-bit data
//
// One tick word is taken every cycle unless a stalled result holds it;
// the input register holds it, the result register its engine result.
// arst_n clears the bus state to idle with SCL and SDA high and driven.
// A stalled result holds the pipeline; cmd.ready drops only when both
// stages are full and res.ready is low.
module i2c_master_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	i2cms_cmd_if.sink                       cmd,
	i2cms_res_if.source                     res,
	input  logic                            cfg_we,
	input  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [i2cms_pkg::CFG_W-1:0]     cfg_wdata
);
	import i2cms_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	cmd_t cmd_s1;
	logic out_valid_q;
	res_t res_q;
	res_t res_n;
	logic adv, step;

	assign adv = !out_valid_q || res.ready;
	assign step = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;
	assign res.valid = out_valid_q;
	assign res.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HALF_PERIOD_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			priority if (cfg_idx == CFG_HALF_PERIOD)
				cfg_q.half_period <= cfg_wdata[HALF_W-1:0];
			else if (cfg_idx == CFG_ACK_TIMEOUT)
				cfg_q.ack_timeout <= cfg_wdata[TOUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) valid_s1 <= cmd.valid;
			if (adv) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) cmd_s1 <= cmd.data;
		if (step) res_q <= res_n;
	end

	i2cms_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_s1),
		.cfg    (cfg_q),
		.res    (res_n)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("engine step lost its result word");
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> cmd.ready)
		else $error("input stalled with empty result register");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> !res_q.busy_res && res_q.status != ST_IGNORED)
		else $error("completion word shows busy or ignored status");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.status == ST_ACK || res_q.status == ST_NAK ||
			res_q.status == ST_IGNORED)
		else $error("undefined status code");
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for i2c_master_sequencer_core: tick words in, pin/status words out.
// Depends on i2cms_pkg and i2cms_if; holds its own bus sequencer predictor and score queue.
// Covers directed commands, register extremes, backpressure and randomized traffic.
module tb_top;
	import i2cms_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	i2cms_cmd_if cmd_ch();
	i2cms_res_if res_ch();

	i2c_master_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	phase_t pr_phase;
	logic [3:0] pr_bits;
	logic [7:0] pr_shift;
	int unsigned pr_ptimer;
	int unsigned pr_atimer;
	logic [7:0] pr_left;
	logic pr_scl, pr_sda, pr_dir;
	logic [1:0] pr_last_st, pr_stop_st;
	logic [7:0] pr_rdata;
	logic pr_done;
	logic [HALF_W-1:0] cfg_half;
	logic [TOUT_W-1:0] cfg_tout;

	res_t due_words[$];
	res_t want;
	int mismatches = 0;
	int seen_words = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold = 0;

	function automatic void go(phase_t p);
		pr_phase = p;
		pr_ptimer = 0;
		case (p)
			PH_ST_A: pr_scl = 1'b1;
			PH_ST_B: begin
				pr_sda = 1'b0;
				pr_dir = 1'b1;
			end
			PH_TX_LOW: pr_scl = 1'b0;
			PH_TX_DATA: begin
				pr_sda = pr_shift[7];
				pr_dir = 1'b1;
			end
			PH_TX_HIGH: pr_scl = 1'b1;
			PH_AK_LOW: begin
				pr_scl = 1'b0;
				pr_dir = 1'b0;
			end
			PH_AK_HIGH: begin
				pr_scl = 1'b1;
				pr_atimer = 0;
			end
			PH_RX_LOW: begin
				pr_scl = 1'b0;
				pr_dir = 1'b0;
			end
			PH_RX_HIGH: pr_scl = 1'b1;
			PH_RA_LOW: pr_scl = 1'b0;
			PH_RA_DATA: begin
				pr_sda = (pr_left == 8'd0);
				pr_dir = 1'b1;
			end
			PH_RA_HIGH: pr_scl = 1'b1;
			PH_RA_END: pr_scl = 1'b0;
			PH_SP_A: pr_scl = 1'b0;
			PH_SP_B: begin
				pr_sda = 1'b0;
				pr_dir = 1'b1;
			end
			PH_SP_C: pr_scl = 1'b1;
			PH_SP_D: begin
				pr_sda = 1'b1;
				pr_dir = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic void complete(logic [1:0] st);
		pr_phase = PH_IDLE;
		pr_ptimer = 0;
		pr_last_st = st;
		pr_done = 1'b1;
	endfunction

	function automatic res_t step_bus(cmd_t w);
		logic ignored;
		res_t r;
		ignored = 1'b0;
		pr_done = 1'b0;
		if (pr_phase == PH_IDLE) begin
			case (w.func)
				FUNC_START_WR, FUNC_START_RD: begin
					if (w.func == FUNC_START_RD)
						pr_left = w.byte_count;
					pr_shift = {w.addr, w.func == FUNC_START_RD};
					pr_bits = '0;
					go(PH_ST_A);
				end
				FUNC_WRITE: begin
					pr_shift = w.wdata;
					pr_bits = '0;
					go(PH_TX_LOW);
				end
				FUNC_READ: begin
					if (pr_left == 8'd0) begin
						pr_rdata = '0;
						complete(ST_ACK);
					end else begin
						pr_shift = '0;
						pr_bits = '0;
						go(PH_RX_LOW);
					end
				end
				FUNC_STOP: begin
					pr_stop_st = ST_ACK;
					go(PH_SP_A);
				end
				default: ;
			endcase
		end else begin
			ignored = (w.func >= FUNC_START_WR) && (w.func <= FUNC_STOP);
			if (pr_phase == PH_AK_HIGH) begin
				if (!w.sda_level) begin
					complete(ST_ACK);
				end else begin
					if (pr_atimer < TIMER_MAX)
						pr_atimer++;
					if (pr_atimer >= cfg_tout || pr_atimer >= TIMER_MAX)
						complete(ST_NAK);
				end
			end else begin
				pr_ptimer++;
				if (pr_ptimer >= cfg_half) begin
					case (pr_phase)
						PH_ST_A: go(PH_ST_B);
						PH_ST_B: begin
							pr_bits = '0;
							go(PH_TX_LOW);
						end
						PH_TX_LOW: go(PH_TX_DATA);
						PH_TX_DATA: go(PH_TX_HIGH);
						PH_TX_HIGH: begin
							pr_shift = pr_shift << 1;
							pr_bits++;
							go(pr_bits >= BITS_PER_BYTE ? PH_AK_LOW : PH_TX_LOW);
						end
						PH_AK_LOW: go(PH_AK_HIGH);
						PH_RX_LOW: go(PH_RX_HIGH);
						PH_RX_HIGH: begin
							pr_shift = {pr_shift[6:0], w.sda_level};
							pr_bits++;
							if (pr_bits >= BITS_PER_BYTE) begin
								pr_rdata = pr_shift;
								pr_left--;
								go(PH_RA_LOW);
							end else begin
								go(PH_RX_LOW);
							end
						end
						PH_RA_LOW: go(PH_RA_DATA);
						PH_RA_DATA: go(PH_RA_HIGH);
						PH_RA_HIGH: go(PH_RA_END);
						PH_RA_END: begin
							// last byte answered NAK: automatic stop follows
							if (pr_left == 8'd0) begin
								pr_stop_st = ST_NAK;
								go(PH_SP_A);
							end else begin
								complete(ST_ACK);
							end
						end
						PH_SP_A: go(PH_SP_B);
						PH_SP_B: go(PH_SP_C);
						PH_SP_C: go(PH_SP_D);
						PH_SP_D: complete(pr_stop_st);
						default: complete(ST_ACK);
					endcase
				end
			end
		end
		r.scl_out = pr_scl;
		r.sda_out = pr_sda;
		r.sda_drive = pr_dir;
		r.busy_res = (pr_phase != PH_IDLE);
		r.done_res = pr_done;
		r.status = pr_done ? pr_last_st : (ignored ? ST_IGNORED : pr_last_st);
		r.rdata = pr_rdata;
		r.remaining = pr_left;
		return r;
	endfunction

	// stimulus side
	task automatic send_word(cmd_t w);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= w;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		due_words.push_back(step_bus(w));
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HALF_PERIOD)
			cfg_half = val[HALF_W-1:0];
		else
			cfg_tout = val[TOUT_W-1:0];
	endtask

	task automatic set_timing(logic [HALF_W-1:0] hp, logic [TOUT_W-1:0] tout);
		drain();
		write_reg(CFG_HALF_PERIOD, CFG_W'(hp));
		write_reg(CFG_ACK_TIMEOUT, CFG_W'(tout));
	endtask

	// one command, then filler ticks until the bus sequencer is idle again;
	// acked: target pulls SDA low at random during the ACK wait, else holds it high
	task automatic issue(logic [2:0] f, logic [6:0] a, logic [7:0] d, logic [7:0] n,
			logic acked, logic [2:0] busy_f);
		cmd_t w;
		w = '{func: f, addr: a, wdata: d, byte_count: n, sda_level: 1'($urandom_range(1))};
		send_word(w);
		while (pr_phase != PH_IDLE) begin
			w.func = busy_f;
			w.addr = 7'($urandom);
			w.wdata = 8'($urandom);
			w.byte_count = 8'($urandom);
			if (pr_phase == PH_AK_HIGH)
				w.sda_level = acked ? ($urandom_range(3) != 0) : 1'b1;
			else
				w.sda_level = 1'($urandom_range(1));
			send_word(w);
		end
	endtask

	function automatic cmd_t rand_tick();
		cmd_t w;
		int unsigned r;
		w.addr = 7'($urandom);
		w.wdata = 8'($urandom);
		w.byte_count = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		w.sda_level = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (pr_phase != PH_IDLE)
			w.func = (r < 10) ? 3'($urandom_range(7)) : FUNC_NONE;
		else if (r < 15)
			w.func = FUNC_START_WR;
		else if (r < 30)
			w.func = FUNC_START_RD;
		else if (r < 55)
			w.func = FUNC_WRITE;
		else if (r < 75)
			w.func = FUNC_READ;
		else if (r < 88)
			w.func = FUNC_STOP;
		else if (r < 94)
			w.func = FUNC_NONE;
		else
			w.func = 3'($urandom_range(7, 6));
		return w;
	endfunction

	// result side
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic void cmp_field(string nm, logic [7:0] exp_v, logic [7:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("word %0d %s: expected %0h, got %0h", seen_words, nm, exp_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %0h", res_ch.data);
			end else begin
				want = due_words.pop_front();
				cmp_field("scl_out", 8'(want.scl_out), 8'(res_ch.data.scl_out));
				cmp_field("sda_out", 8'(want.sda_out), 8'(res_ch.data.sda_out));
				cmp_field("sda_drive", 8'(want.sda_drive), 8'(res_ch.data.sda_drive));
				cmp_field("busy_res", 8'(want.busy_res), 8'(res_ch.data.busy_res));
				cmp_field("done_res", 8'(want.done_res), 8'(res_ch.data.done_res));
				cmp_field("status", 8'(want.status), 8'(res_ch.data.status));
				cmp_field("rdata", want.rdata, res_ch.data.rdata);
				cmp_field("remaining", want.remaining, res_ch.data.remaining);
			end
			seen_words++;
		end
	end

	// tests
	task automatic test_directed();
		issue(FUNC_NONE, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_READ, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_START_WR, 7'h7F, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_WRITE, 7'h00, 8'hFF, 8'h00, 1'b1, FUNC_WRITE);
		issue(FUNC_WRITE, 7'h00, 8'h00, 8'h00, 1'b0, FUNC_NONE);
		issue(FUNC_STOP, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_READ);
		issue(FUNC_START_RD, 7'h00, 8'h00, 8'd2, 1'b1, FUNC_STOP);
		issue(FUNC_READ, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_START_RD);
		issue(FUNC_READ, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_START_WR);
		issue(FUNC_READ, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		issue(3'd6, 7'h7F, 8'hFF, 8'hFF, 1'b1, FUNC_NONE);
		issue(3'd7, 7'h7F, 8'hFF, 8'hFF, 1'b1, FUNC_NONE);
		issue(FUNC_START_RD, 7'h55, 8'h00, 8'd255, 1'b1, 3'd7);
		issue(FUNC_READ, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_STOP, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		set_timing(16'd1, 24'd1);
		issue(FUNC_START_WR, 7'h2A, 8'h00, 8'h00, 1'b0, FUNC_NONE);
		issue(FUNC_STOP, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		set_timing(16'd0, 24'd100);
		issue(FUNC_WRITE, 7'h00, 8'hA5, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_STOP, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		set_timing(16'd3, 24'd100);
		issue(FUNC_START_RD, 7'h33, 8'h00, 8'd1, 1'b1, FUNC_NONE);
		issue(FUNC_READ, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_WRITE);
	endtask

	task automatic test_extremes();
		set_timing(16'd16, 24'd100);
		issue(FUNC_STOP, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		set_timing(16'd1, 24'hFFFFFF);
		issue(FUNC_START_WR, 7'h4C, 8'h00, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_WRITE, 7'h00, 8'h3C, 8'h00, 1'b1, FUNC_NONE);
		issue(FUNC_STOP, 7'h00, 8'h00, 8'h00, 1'b1, FUNC_NONE);
	endtask

	task automatic test_backpressure();
		set_timing(16'd1, 24'd4);
		repeat (10) send_word(rand_tick());
		rx_hold = 80;
		repeat (40) send_word(rand_tick());
		drain();
		repeat (20) send_word(rand_tick());
	endtask

	task automatic random_traffic(int n, int tx_pct, int rx_pct,
			logic [HALF_W-1:0] hp, logic [TOUT_W-1:0] tout);
		set_timing(hp, tout);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (n) send_word(rand_tick());
	endtask

	task automatic test_random();
		random_traffic(50, 0, 0, 16'd1, 24'd3);
		random_traffic(50, 63, 0, 16'd2, 24'd100);
		random_traffic(50, 0, 63, 16'd1, 24'd1);
		random_traffic(50, 9, 9, 16'd3, 24'd5);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		pr_phase = PH_IDLE;
		pr_bits = '0;
		pr_shift = '0;
		pr_ptimer = 0;
		pr_atimer = 0;
		pr_left = '0;
		pr_scl = 1'b1;
		pr_sda = 1'b1;
		pr_dir = 1'b1;
		pr_last_st = ST_ACK;
		pr_stop_st = ST_ACK;
		pr_rdata = '0;
		pr_done = 1'b0;
		cfg_half = HALF_PERIOD_RST;
		cfg_tout = ACK_TIMEOUT_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_extremes();
		test_backpressure();
		test_random();
		drain();

		if (mismatches == 0 && due_words.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#(8 * 3000000);
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
design/i2cms_pkg.sv
design/i2cms_if.sv
design/i2cms_engine.sv
design/i2c_master_sequencer_core.sv
test/tb_top.sv
